@@ hw/rtl/mds_pkg.sv @@
// Shared constants, command and status types for the markdown strip stream.
package mds_pkg;

	localparam int MAX_LINK_TEXT = 16;
	localparam int CNT_W         = $clog2(MAX_LINK_TEXT + 1);
	localparam int ST_AW         = (MAX_LINK_TEXT > 1) ? $clog2(MAX_LINK_TEXT) : 1;
	localparam int STK_DEPTH     = MAX_LINK_TEXT + 2;
	localparam int STK_CW        = $clog2(STK_DEPTH + 1);
	localparam int STK_AW        = $clog2(STK_DEPTH);
	localparam int RES_KEEP      = 39;
	localparam int RES_W         = $clog2(RES_KEEP + 1);

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_TICK  = 8'h60;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUERY = 8'h3F;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		ACT_DONE,
		ACT_NL2,
		ACT_LINK_OUT,
		ACT_REPLAY_X,
		ACT_REPLAY_C
	} act_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_HELD,
		CMD_STEP,
		CMD_NL_SPACE,
		CMD_POP,
		CMD_PUSH_CUR,
		CMD_PUSH_CLOSE,
		CMD_PUSH_STORE,
		CMD_OPEN,
		CMD_LINK_EMIT,
		CMD_FLUSH_HELD,
		CMD_SUMMARY,
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		logic held_valid;
		logic held_drop;
		act_t act;
		logic stack_empty;
		logic cnt_zero;
		logic sweep_last;
		logic emit_ok;
		logic in_link;
		logic in_close;
	} status_t;

endpackage

@@ hw/rtl/mds_ctrl.sv @@
// Sequencer that steps the datapath through one action per cycle, holding while the output has no room.
module mds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              is_last,
	output logic              in_stall,
	input  mds_pkg::status_t  status,
	output mds_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_FEED,
		S_NL_SPACE,
		S_LINK_EMIT,
		S_PUSH_CUR_C,
		S_PUSH_CUR,
		S_PUSH_CLOSE,
		S_SWEEP,
		S_OPEN,
		S_NEXT,
		S_FLUSH,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t nxt;
	logic   last_q;
	logic   in_stall_q;

	always_comb begin
		nxt = state_q;
		cmd = mds_pkg::CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd = mds_pkg::CMD_LOAD;
					nxt = S_FEED;
				end
			end
			S_FEED: begin
				if (status.emit_ok) begin
					if (status.held_valid) begin
						cmd = mds_pkg::CMD_HELD;
						if (status.held_drop) begin
							nxt = S_NEXT;
						end
					end else begin
						cmd = mds_pkg::CMD_STEP;
						unique case (status.act)
							mds_pkg::ACT_NL2:      nxt = S_NL_SPACE;
							mds_pkg::ACT_LINK_OUT: nxt = S_LINK_EMIT;
							mds_pkg::ACT_REPLAY_X: nxt = S_PUSH_CUR;
							mds_pkg::ACT_REPLAY_C: nxt = S_PUSH_CUR_C;
							default:               nxt = S_NEXT;
						endcase
					end
				end
			end
			S_NL_SPACE: begin
				if (status.emit_ok) begin
					cmd = mds_pkg::CMD_NL_SPACE;
					nxt = S_NEXT;
				end
			end
			S_LINK_EMIT: begin
				if (status.emit_ok) begin
					cmd = mds_pkg::CMD_LINK_EMIT;
					if (status.sweep_last) begin
						nxt = S_NEXT;
					end
				end
			end
			S_PUSH_CUR_C: begin
				cmd = mds_pkg::CMD_PUSH_CUR;
				nxt = S_PUSH_CLOSE;
			end
			S_PUSH_CUR: begin
				cmd = mds_pkg::CMD_PUSH_CUR;
				nxt = status.cnt_zero ? S_OPEN : S_SWEEP;
			end
			S_PUSH_CLOSE: begin
				cmd = mds_pkg::CMD_PUSH_CLOSE;
				nxt = status.cnt_zero ? S_OPEN : S_SWEEP;
			end
			S_SWEEP: begin
				cmd = mds_pkg::CMD_PUSH_STORE;
				if (status.sweep_last) begin
					nxt = S_OPEN;
				end
			end
			S_OPEN: begin
				if (status.emit_ok) begin
					cmd = mds_pkg::CMD_OPEN;
					nxt = S_NEXT;
				end
			end
			S_NEXT: begin
				if (!status.stack_empty) begin
					cmd = mds_pkg::CMD_POP;
					nxt = S_FEED;
				end else if (last_q) begin
					nxt = S_FLUSH;
				end else begin
					nxt = S_FINISH;
				end
			end
			S_FLUSH: begin
				if (status.held_valid) begin
					if (status.emit_ok) begin
						cmd = mds_pkg::CMD_FLUSH_HELD;
					end
				end else if (status.in_link) begin
					nxt = status.cnt_zero ? S_OPEN : S_SWEEP;
				end else if (status.in_close) begin
					nxt = S_PUSH_CLOSE;
				end else if (status.emit_ok) begin
					cmd = mds_pkg::CMD_SUMMARY;
					nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				if (status.emit_ok) begin
					cmd = mds_pkg::CMD_FINISH;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			last_q     <= 1'b0;
			in_stall_q <= 1'b0;
		end else begin
			state_q    <= nxt;
			in_stall_q <= (nxt != S_IDLE);
			if (cmd == mds_pkg::CMD_LOAD) begin
				last_q <= is_last;
			end
		end
	end

	assign in_stall = in_stall_q;

endmodule

@@ hw/rtl/mds_dpath.sv @@
// Datapath: filter state, link text store, replay stack and result stages.
module mds_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_char,
	input  mds_pkg::cmd_t     cmd,
	output mds_pkg::status_t  status,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [7:0]        out_char,
	output logic              kind,
	output logic [15:0]       out_length,
	output logic              run_last
);

	typedef enum logic [2:0] {
		M_NORMAL,
		M_HASH,
		M_SPACE,
		M_LINK,
		M_CLOSE,
		M_URL
	} mode_t;

	logic [7:0]                  cur_q;
	logic [7:0]                  held_char_q;
	logic                        held_valid_q;
	logic                        ls_q;
	mode_t                       mode_q;
	logic [7:0]                  store_q [mds_pkg::MAX_LINK_TEXT];
	logic [mds_pkg::CNT_W-1:0]   lcnt_q;
	logic [mds_pkg::CNT_W-1:0]   idx_q;
	logic [7:0]                  lastem_q;
	logic [15:0]                 ecnt_q;
	logic [7:0]                  stk_q [mds_pkg::STK_DEPTH];
	logic [mds_pkg::STK_CW-1:0]  sp_q;
	logic [mds_pkg::RES_W-1:0]   resn_q;
	logic                        pend_v_q;
	logic [7:0]                  pend_c_q;
	logic                        pend_k_q;
	logic [15:0]                 pend_len_q;
	logic                        out_valid_q;
	logic [7:0]                  out_char_q;
	logic                        out_kind_q;
	logic [15:0]                 out_len_q;
	logic                        out_last_q;

	logic                        held_drop;
	logic                        term;
	logic [mds_pkg::CNT_W-1:0]   st_addr;
	logic [7:0]                  st_rd;
	logic                        sweep_last;
	logic [mds_pkg::STK_CW-1:0]  sp_m1;

	// step decode
	mode_t                       n_mode;
	logic                        n_ls;
	logic                        n_held_v;
	logic [7:0]                  n_held_c;
	logic                        st_we;
	logic [mds_pkg::CNT_W-1:0]   n_lcnt;
	logic                        step_em;
	logic [7:0]                  step_ch;
	mds_pkg::act_t               act;
	logic                        norm;

	logic                        em_req;
	logic [7:0]                  em_char;
	logic                        push_req;
	logic [7:0]                  push_data;
	logic                        keep;
	logic                        stage;
	logic                        mv;
	logic                        slot_free;
	logic                        emit_ok;

	assign held_drop = held_valid_q &&
		((held_char_q == mds_pkg::CH_STAR && cur_q == mds_pkg::CH_STAR) ||
		 (ls_q && cur_q == mds_pkg::CH_SPACE));
	assign term = (lastem_q == mds_pkg::CH_DOT) || (lastem_q == mds_pkg::CH_BANG) ||
		(lastem_q == mds_pkg::CH_QUERY) || (lastem_q == mds_pkg::CH_NL);

	// push sweep reads the store from the top down, link output from the bottom up
	assign st_addr = (cmd == mds_pkg::CMD_LINK_EMIT) ? idx_q :
		(lcnt_q - mds_pkg::CNT_W'(1) - idx_q);
	assign st_rd      = store_q[st_addr[mds_pkg::ST_AW-1:0]];
	assign sweep_last = ((idx_q + mds_pkg::CNT_W'(1)) == lcnt_q);
	assign sp_m1      = sp_q - mds_pkg::STK_CW'(1);

	always_comb begin
		n_mode   = mode_q;
		n_ls     = ls_q;
		n_held_v = held_valid_q;
		n_held_c = held_char_q;
		st_we    = 1'b0;
		n_lcnt   = lcnt_q;
		step_em  = 1'b0;
		step_ch  = cur_q;
		act      = mds_pkg::ACT_DONE;
		norm     = 1'b0;
		unique case (mode_q)
			M_HASH: begin
				if (cur_q == mds_pkg::CH_SPACE) begin
					n_mode = M_SPACE;
				end else if (cur_q != mds_pkg::CH_HASH) begin
					n_mode = M_NORMAL;
					norm   = 1'b1;
				end
			end
			M_SPACE: begin
				if (cur_q != mds_pkg::CH_SPACE) begin
					n_mode = M_NORMAL;
					norm   = 1'b1;
				end
			end
			M_LINK: begin
				if (cur_q == mds_pkg::CH_RBRK) begin
					n_mode = M_CLOSE;
				end else if (lcnt_q < mds_pkg::CNT_W'(mds_pkg::MAX_LINK_TEXT)) begin
					st_we  = 1'b1;
					n_lcnt = lcnt_q + mds_pkg::CNT_W'(1);
				end else begin
					act = mds_pkg::ACT_REPLAY_X;
				end
			end
			M_CLOSE: begin
				if (cur_q == mds_pkg::CH_LPAR) begin
					if (lcnt_q == '0) begin
						n_mode = M_URL;
					end else begin
						act = mds_pkg::ACT_LINK_OUT;
					end
				end else begin
					act = mds_pkg::ACT_REPLAY_C;
				end
			end
			M_URL: begin
				if (cur_q == mds_pkg::CH_RPAR) begin
					n_mode = M_NORMAL;
					n_ls   = 1'b0;
				end
			end
			default: begin
				n_mode = M_NORMAL;
				norm   = 1'b1;
			end
		endcase
		if (norm) begin
			priority if (ls_q && cur_q == mds_pkg::CH_HASH) begin
				n_mode = M_HASH;
				n_ls   = 1'b0;
			end else if (cur_q == mds_pkg::CH_STAR || (ls_q && cur_q == mds_pkg::CH_DASH)) begin
				n_held_c = cur_q;
				n_held_v = 1'b1;
			end else if (cur_q == mds_pkg::CH_LBRK) begin
				n_mode = M_LINK;
				n_lcnt = '0;
				n_ls   = 1'b0;
			end else begin
				n_ls = (cur_q == mds_pkg::CH_NL);
				if (cur_q == mds_pkg::CH_NL) begin
					if (ecnt_q != 16'd0) begin
						step_em = 1'b1;
						if (term) begin
							step_ch = mds_pkg::CH_SPACE;
						end else begin
							step_ch = mds_pkg::CH_DOT;
							act     = mds_pkg::ACT_NL2;
						end
					end
				end else if (cur_q != mds_pkg::CH_TICK) begin
					step_em = 1'b1;
				end
			end
		end
	end

	always_comb begin
		em_req    = 1'b0;
		em_char   = held_char_q;
		push_req  = 1'b0;
		push_data = cur_q;
		unique case (cmd)
			mds_pkg::CMD_HELD:       em_req = !held_drop;
			mds_pkg::CMD_FLUSH_HELD: em_req = 1'b1;
			mds_pkg::CMD_STEP: begin
				em_req  = step_em;
				em_char = step_ch;
			end
			mds_pkg::CMD_NL_SPACE: begin
				em_req  = 1'b1;
				em_char = mds_pkg::CH_SPACE;
			end
			mds_pkg::CMD_OPEN: begin
				em_req  = 1'b1;
				em_char = mds_pkg::CH_LBRK;
			end
			mds_pkg::CMD_LINK_EMIT: begin
				em_req  = 1'b1;
				em_char = st_rd;
			end
			mds_pkg::CMD_PUSH_CUR:   push_req = 1'b1;
			mds_pkg::CMD_PUSH_CLOSE: begin
				push_req  = 1'b1;
				push_data = mds_pkg::CH_RBRK;
			end
			mds_pkg::CMD_PUSH_STORE: begin
				push_req  = 1'b1;
				push_data = st_rd;
			end
			default: em_req = 1'b0;
		endcase
	end

	assign keep      = em_req && (resn_q < mds_pkg::RES_W'(mds_pkg::RES_KEEP));
	assign stage     = keep || (cmd == mds_pkg::CMD_SUMMARY);
	assign mv        = pend_v_q && (stage || cmd == mds_pkg::CMD_FINISH);
	assign slot_free = !out_valid_q || !out_stall;
	assign emit_ok   = !pend_v_q || slot_free;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_char_q  <= '0;
			held_valid_q <= 1'b0;
			ls_q         <= 1'b1;
			mode_q       <= M_NORMAL;
			lcnt_q       <= '0;
			idx_q        <= '0;
			lastem_q     <= '0;
			ecnt_q       <= '0;
			sp_q         <= '0;
			resn_q       <= '0;
			pend_v_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// hold the sweep index while the sequencer waits for room
			if (cmd == mds_pkg::CMD_PUSH_STORE || cmd == mds_pkg::CMD_LINK_EMIT) begin
				idx_q <= sweep_last ? '0 : (idx_q + mds_pkg::CNT_W'(1));
			end else if (cmd != mds_pkg::CMD_NONE) begin
				idx_q <= '0;
			end
			if (em_req) begin
				lastem_q <= em_char;
				if (ecnt_q != 16'hFFFF) begin
					ecnt_q <= ecnt_q + 16'd1;
				end
			end
			if (keep) begin
				resn_q <= resn_q + mds_pkg::RES_W'(1);
			end
			if (push_req) begin
				sp_q <= sp_q + mds_pkg::STK_CW'(1);
			end
			unique case (cmd)
				mds_pkg::CMD_LOAD: resn_q <= '0;
				mds_pkg::CMD_HELD, mds_pkg::CMD_FLUSH_HELD: begin
					held_valid_q <= 1'b0;
					held_char_q  <= '0;
					ls_q         <= 1'b0;
				end
				mds_pkg::CMD_STEP: begin
					mode_q       <= n_mode;
					ls_q         <= n_ls;
					held_valid_q <= n_held_v;
					held_char_q  <= n_held_c;
					lcnt_q       <= n_lcnt;
				end
				mds_pkg::CMD_POP: sp_q <= sp_m1;
				mds_pkg::CMD_OPEN: begin
					mode_q <= M_NORMAL;
					lcnt_q <= '0;
					ls_q   <= 1'b0;
				end
				mds_pkg::CMD_LINK_EMIT: begin
					if (sweep_last) begin
						lcnt_q <= '0;
						mode_q <= M_URL;
					end
				end
				mds_pkg::CMD_SUMMARY: begin
					held_valid_q <= 1'b0;
					held_char_q  <= '0;
					ls_q         <= 1'b1;
					mode_q       <= M_NORMAL;
					lcnt_q       <= '0;
					lastem_q     <= '0;
					ecnt_q       <= '0;
				end
				default: ;
			endcase
			if (stage) begin
				pend_v_q <= 1'b1;
			end else if (cmd == mds_pkg::CMD_FINISH) begin
				pend_v_q <= 1'b0;
			end
			if (mv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload storage
	always_ff @(posedge clk) begin
		if (cmd == mds_pkg::CMD_LOAD) begin
			cur_q <= in_char;
		end else if (cmd == mds_pkg::CMD_POP) begin
			cur_q <= stk_q[sp_m1[mds_pkg::STK_AW-1:0]];
		end
		if (cmd == mds_pkg::CMD_STEP && st_we) begin
			store_q[lcnt_q[mds_pkg::ST_AW-1:0]] <= cur_q;
		end
		if (push_req) begin
			stk_q[sp_q[mds_pkg::STK_AW-1:0]] <= push_data;
		end
		if (mv) begin
			out_char_q <= pend_c_q;
			out_kind_q <= pend_k_q;
			out_len_q  <= pend_len_q;
			out_last_q <= (cmd == mds_pkg::CMD_FINISH);
		end
		if (stage) begin
			if (cmd == mds_pkg::CMD_SUMMARY) begin
				pend_c_q   <= '0;
				pend_k_q   <= 1'b1;
				pend_len_q <= ecnt_q;
			end else begin
				pend_c_q   <= em_char;
				pend_k_q   <= 1'b0;
				pend_len_q <= '0;
			end
		end
	end

	assign status.held_valid  = held_valid_q;
	assign status.held_drop   = held_drop;
	assign status.act         = act;
	assign status.stack_empty = (sp_q == '0);
	assign status.cnt_zero    = (lcnt_q == '0);
	assign status.sweep_last  = sweep_last;
	assign status.emit_ok     = emit_ok;
	assign status.in_link     = (mode_q == M_LINK);
	assign status.in_close    = (mode_q == M_CLOSE);

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign kind       = out_kind_q;
	assign out_length = out_len_q;
	assign run_last   = out_last_q;

	a_stack_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_req |-> (sp_q < mds_pkg::STK_CW'(mds_pkg::STK_DEPTH)))
		else $error("replay stack overflow");

	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(stage && pend_v_q) |-> slot_free)
		else $error("result staged over an unsent beat");

	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == mds_pkg::CMD_STEP && st_we) |->
			(lcnt_q < mds_pkg::CNT_W'(mds_pkg::MAX_LINK_TEXT)))
		else $error("link store written past its end");

	a_summary_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == mds_pkg::CMD_SUMMARY) |-> (sp_q == '0 && !held_valid_q &&
			mode_q != M_LINK && mode_q != M_CLOSE))
		else $error("summary issued with work outstanding");

	a_finish_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == mds_pkg::CMD_FINISH) |=> !pend_v_q)
		else $error("step ended with a result still staged");

endmodule

@@ hw/rtl/markdown_strip_stream.sv @@
// Top level of the markdown strip stream filter: sequencer plus datapath.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   input    | in_valid / in_stall    | in_char, is_last
//   output   | out_valid / out_stall  | out_char, kind, out_length, run_last
//
// Flow: one input beat at a time. A plain byte passes through accept, filter,
//   step end and hand-off of the final result; a held '*' or '-' adds a step, and a
//   newline that expands to ". " adds a step. Link text leaves at one byte a cycle
//   while the output has room; each byte of a failed link is pushed, popped and
//   filtered again.
// Reset: arst_n clears the control state at once; the link store needs no clearing.
// Stalls: results pass through a staging register and an output register, so one
//   result waits in each while out_stall is high; the sequencer holds until room.
module markdown_strip_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_char,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_char,
	output logic        kind,
	output logic [15:0] out_length,
	output logic        run_last
);

	// command from the sequencer, status back from the datapath
	mds_pkg::cmd_t    cmd;
	mds_pkg::status_t status;

	// Sequencer: accepts a beat only when idle, then walks the held-byte check,
	// the mode step, replay pushes and pops, end-of-text flush and the summary.
	mds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.is_last  (is_last),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: filter state, link store, replay stack (a failed link is pushed
	// back in reverse so that it is read out ahead of anything still pending),
	// and the staging and output registers that mark the last result of a step.
	mds_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_char    (in_char),
		.cmd        (cmd),
		.status     (status),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_char   (out_char),
		.kind       (kind),
		.out_length (out_length),
		.run_last   (run_last)
	);

endmodule

@@ tb/tb_markdown_strip_stream.sv @@
// Self-checking testbench for markdown_strip_stream: directed table, then random markdown texts.
module tb_markdown_strip_stream;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_ITEMS   = 160;
	localparam int PHASE_LEN    = 95;   // beats per idling profile
	localparam int QUIET_LIMIT  = 2000; // cycles with no beat on either side
	localparam int DRAIN_CYCLES = 64;

	// Scan state of the filter as the predictor tracks it.
	typedef enum logic [2:0] {
		SC_NORMAL,
		SC_HASH,
		SC_SPACE,
		SC_LINK,
		SC_CLOSE,
		SC_URL
	} scan_t;

	// One result of the block: a plain-text byte or the end-of-text summary.
	typedef struct packed {
		logic [7:0]  ch;
		logic        kind;
		logic [15:0] len;
		logic        run_end;
	} text_res_t;

	// Directed rows. An empty text stands for a single NUL byte. Typed rows carry the
	// result bytes (and the summary length when the row closes the text) by hand.
	typedef struct {
		string txt;
		bit    last;
		bit    typed;
		string want;
		int    want_len;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_char;
	logic        is_last;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_char;
	logic        kind;
	logic [15:0] out_length;
	logic        run_last;

	// Predictor state: a private copy of the filter.
	logic [7:0]  hold_ch;
	logic        hold_v;
	logic        at_bol;
	scan_t       scan;
	logic [7:0]  link_buf [mds_pkg::MAX_LINK_TEXT];
	int          link_cnt;
	logic [7:0]  prev_out;
	logic [15:0] out_total;

	text_res_t   step_res [$];   // results of the beat being predicted
	text_res_t   plain_q [$];    // predicted results still to come out of the block
	logic [7:0]  text_bytes [$]; // random text under construction

	int          mismatches;
	int          beats_in;
	int          quiet_cycles;
	int          tx_idle_pct;
	int          rx_stall_pct;
	text_res_t   seen;
	text_res_t   owed;

	markdown_strip_stream u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_char    (in_char),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.kind       (kind),
		.out_length (out_length),
		.run_last   (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void strip_reset();
		hold_ch   = 8'h00;
		hold_v    = 1'b0;
		at_bol    = 1'b1;
		scan      = SC_NORMAL;
		link_cnt  = 0;
		prev_out  = 8'h00;
		out_total = 16'd0;
	endfunction

	// Count every output byte, but keep only as many per beat as the block can return.
	function automatic void put_byte(input logic [7:0] c);
		prev_out = c;
		if (out_total != 16'hFFFF)
			out_total++;
		if (step_res.size() < mds_pkg::RES_KEEP)
			step_res.push_back('{c, 1'b0, 16'd0, 1'b0});
	endfunction

	// Not a link after all: emit '[' as a literal and push the buffered text back
	// through the filter, with ']' and the byte that broke the link if there were any.
	function automatic void replay_link(input logic with_close, input logic with_extra,
			input logic [7:0] extra);
		logic [7:0] seq [$];
		int k;
		for (k = 0; k < link_cnt && k < mds_pkg::MAX_LINK_TEXT; k++)
			seq.push_back(link_buf[k]);
		if (with_close)
			seq.push_back(mds_pkg::CH_RBRK);
		if (with_extra)
			seq.push_back(extra);
		scan     = SC_NORMAL;
		link_cnt = 0;
		at_bol   = 1'b0;
		put_byte(mds_pkg::CH_LBRK);
		foreach (seq[i])
			filter_byte(seq[i]);
	endfunction

	function automatic void filter_byte(input logic [7:0] b);
		logic [7:0] h;
		logic ls;
		int k;
		// A held '*' or line-start '-' is settled by the byte after it.
		if (hold_v) begin
			h       = hold_ch;
			ls      = at_bol;
			hold_v  = 1'b0;
			hold_ch = 8'h00;
			at_bol  = 1'b0;
			if (h == mds_pkg::CH_STAR && b == mds_pkg::CH_STAR)
				return;
			if (ls && b == mds_pkg::CH_SPACE)
				return;
			put_byte(h);
		end
		case (scan)
		SC_HASH: begin
			if (b == mds_pkg::CH_HASH)
				return;
			if (b == mds_pkg::CH_SPACE) begin
				scan = SC_SPACE;
				return;
			end
			scan = SC_NORMAL;
		end
		SC_SPACE: begin
			if (b == mds_pkg::CH_SPACE)
				return;
			scan = SC_NORMAL;
		end
		SC_LINK: begin
			if (b == mds_pkg::CH_RBRK) begin
				scan = SC_CLOSE;
				return;
			end
			if (link_cnt < mds_pkg::MAX_LINK_TEXT) begin
				link_buf[link_cnt] = b;
				link_cnt++;
				return;
			end
			replay_link(1'b0, 1'b1, b);
			return;
		end
		SC_CLOSE: begin
			if (b == mds_pkg::CH_LPAR) begin
				for (k = 0; k < link_cnt; k++)
					put_byte(link_buf[k]);
				link_cnt = 0;
				scan     = SC_URL;
				return;
			end
			replay_link(1'b1, 1'b1, b);
			return;
		end
		SC_URL: begin
			if (b == mds_pkg::CH_RPAR) begin
				scan   = SC_NORMAL;
				at_bol = 1'b0;
			end
			return;
		end
		default: scan = SC_NORMAL;
		endcase

		if (at_bol && b == mds_pkg::CH_HASH) begin
			scan   = SC_HASH;
			at_bol = 1'b0;
			return;
		end
		if (b == mds_pkg::CH_STAR || (at_bol && b == mds_pkg::CH_DASH)) begin
			hold_ch = b;
			hold_v  = 1'b1;
			return;
		end
		if (b == mds_pkg::CH_LBRK) begin
			scan     = SC_LINK;
			link_cnt = 0;
			at_bol   = 1'b0;
			return;
		end
		at_bol = (b == mds_pkg::CH_NL);
		if (b == mds_pkg::CH_TICK)
			return;
		if (b == mds_pkg::CH_NL) begin
			// Nothing before any output, else ". " or just " " after a sentence end.
			if (out_total == 16'd0)
				return;
			if (!(prev_out inside {mds_pkg::CH_DOT, mds_pkg::CH_BANG, mds_pkg::CH_QUERY,
					mds_pkg::CH_NL}))
				put_byte(mds_pkg::CH_DOT);
			put_byte(mds_pkg::CH_SPACE);
			return;
		end
		put_byte(b);
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic logic [7:0] letter();
		return 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	function automatic void add_word(input int n);
		int k;
		for (k = 0; k < n; k++)
			text_bytes.push_back(letter());
	endfunction

	// Present one beat, hold it until taken, then work out what it must produce.
	// Call at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_item(input logic [7:0] c, input logic lst, input bit typed,
			input string want, input int want_len);
		int k;
		int pushed;
		if (beats_in < PHASE_LEN) begin
			tx_idle_pct  = 23;
			rx_stall_pct = 71;
		end else if (beats_in < 2 * PHASE_LEN) begin
			tx_idle_pct  = 71;
			rx_stall_pct = 23;
		end else begin
			tx_idle_pct  = 0;
			rx_stall_pct = 0;
		end
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_char  <= c;
		is_last  <= lst;
		do
			@(posedge clk);
		while (in_stall);
		beats_in++;

		step_res = {};
		filter_byte(c);
		if (lst) begin
			// End of text: release the held byte, replay any open link, then summarise.
			forever begin
				if (hold_v) begin
					hold_v = 1'b0;
					at_bol = 1'b0;
					put_byte(hold_ch);
					hold_ch = 8'h00;
				end else if (scan == SC_LINK) begin
					replay_link(1'b0, 1'b0, 8'h00);
				end else if (scan == SC_CLOSE) begin
					replay_link(1'b1, 1'b0, 8'h00);
				end else begin
					break;
				end
			end
			step_res.push_back('{8'h00, 1'b1, out_total, 1'b0});
			strip_reset();
		end
		if (step_res.size() > 0)
			step_res[step_res.size() - 1].run_end = 1'b1;

		if (typed) begin
			pushed = 0;
			for (k = 0; k < want.len(); k++) begin
				plain_q.push_back('{want[k], 1'b0, 16'd0, 1'b0});
				pushed++;
			end
			if (lst) begin
				plain_q.push_back('{8'h00, 1'b1, 16'(want_len), 1'b0});
				pushed++;
			end
			if (pushed > 0)
				plain_q[plain_q.size() - 1].run_end = 1'b1;
		end else begin
			foreach (step_res[i])
				plain_q.push_back(step_res[i]);
		end
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------- checking

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s differs, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// Match every output beat against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen = '{out_char, kind, out_length, run_last};
			if (plain_q.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected, actual char %0h kind %0d length %0d last %0d",
					$time, out_char, kind, out_length, run_last);
			end else begin
				owed = plain_q.pop_front();
				check_field("out_char", owed.ch, seen.ch);
				check_field("kind", owed.kind, seen.kind);
				check_field("out_length", owed.len, seen.len);
				check_field("run_last", owed.run_end, seen.run_end);
			end
		end
	end

	// Stall the output side at random, at the rate the current phase sets.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
	end

	// Abandon the run once neither side has moved a beat for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : main
		dir_row_t dir_rows [10];
		int       n;
		int       i;
		int       goal;
		int       k;
		int       rand_beats;
		logic [7:0] c;

		in_valid     = 1'b0;
		in_char      = 8'h00;
		is_last      = 1'b0;
		arst_n       = 1'b0;
		beats_in     = 0;
		tx_idle_pct  = 23;
		rx_stall_pct = 71;
		rand_beats   = 0;
		strip_reset();

		dir_rows = '{
			'{"A", 1'b0, 1'b1, "A", 0},                  // first byte after reset
			'{"\377", 1'b1, 1'b1, "\377", 2},            // top byte value, then summary
			'{"\n", 1'b1, 1'b1, "", 0},                  // newline before any output: empty text
			'{"", 1'b1, 1'b0, "", 0},                    // NUL byte alone
			// header with a space, dash bullet, bold pair, backtick, link, ". " newline
			'{"# h\n- **b`[t](u)\n", 1'b0, 1'b0, "", 0},
			// star bullet, newline after '!', bracket text with no url
			'{"* c!\n[a]d", 1'b0, 1'b0, "", 0},
			// link text overflow
			'{"[0123456789abcdefg", 1'b0, 1'b0, "", 0},
			'{"[x", 1'b1, 1'b0, "", 0},                  // link open at end of text
			'{"[y](z", 1'b1, 1'b0, "", 0},               // url never closed
			'{"[a]", 1'b1, 1'b0, "", 0}                  // text ends right after ']'
		};

		// Hold reset, then release it at a falling edge.
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[r]) begin
			n = (dir_rows[r].txt.len() == 0) ? 1 : dir_rows[r].txt.len();
			for (i = 0; i < n; i++) begin
				c = (dir_rows[r].txt.len() == 0) ? 8'h00 : dir_rows[r].txt[i];
				send_item(c, dir_rows[r].last && (i == n - 1), dir_rows[r].typed,
					dir_rows[r].want, dir_rows[r].want_len);
			end
		end

		// Random texts: mostly well-formed markdown with random content, some noise
		// and broken links. The final byte of each text carries the end mark.
		while (rand_beats < RAND_ITEMS) begin
			text_bytes = {};
			goal = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(3, 24);
			while (text_bytes.size() < goal) begin
				case ($urandom_range(0, 13))
				0, 1, 2: add_word($urandom_range(1, 5));
				3: text_bytes.push_back(mds_pkg::CH_SPACE);
				4: begin
					if ($urandom_range(0, 1) == 1)
						text_bytes.push_back(mds_pkg::CH_DOT);
					text_bytes.push_back(mds_pkg::CH_NL);
				end
				5: begin
					if (text_bytes.size() > 0)
						text_bytes.push_back(mds_pkg::CH_NL);
					repeat ($urandom_range(1, 3)) text_bytes.push_back(mds_pkg::CH_HASH);
					repeat ($urandom_range(0, 2)) text_bytes.push_back(mds_pkg::CH_SPACE);
					add_word($urandom_range(1, 4));
				end
				6: begin
					if (text_bytes.size() > 0)
						text_bytes.push_back(mds_pkg::CH_NL);
					text_bytes.push_back(($urandom_range(0, 1) == 1) ?
						mds_pkg::CH_STAR : mds_pkg::CH_DASH);
					if ($urandom_range(0, 3) != 0)
						text_bytes.push_back(mds_pkg::CH_SPACE);
					add_word($urandom_range(1, 4));
				end
				7: begin
					text_bytes.push_back(mds_pkg::CH_STAR);
					text_bytes.push_back(mds_pkg::CH_STAR);
					add_word($urandom_range(1, 4));
					text_bytes.push_back(mds_pkg::CH_STAR);
					text_bytes.push_back(mds_pkg::CH_STAR);
				end
				8: begin
					text_bytes.push_back(mds_pkg::CH_TICK);
					add_word($urandom_range(1, 4));
					text_bytes.push_back(mds_pkg::CH_TICK);
				end
				9, 10: begin
					text_bytes.push_back(mds_pkg::CH_LBRK);
					n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 6);
					for (k = 0; k < n; k++) begin
						case ($urandom_range(0, 9))
						0: text_bytes.push_back(8'($urandom_range(0, 255)));
						1: text_bytes.push_back(mds_pkg::CH_NL);
						2: text_bytes.push_back(mds_pkg::CH_SPACE);
						default: text_bytes.push_back(letter());
						endcase
					end
					case ($urandom_range(0, 5))
					0, 1, 2: begin
						text_bytes.push_back(mds_pkg::CH_RBRK);
						text_bytes.push_back(mds_pkg::CH_LPAR);
						add_word($urandom_range(1, 4));
						text_bytes.push_back(mds_pkg::CH_RPAR);
					end
					3: begin
						// bracket text with no url after it
						text_bytes.push_back(mds_pkg::CH_RBRK);
						add_word($urandom_range(1, 3));
					end
					4: ; // bracket never closed
					default: begin
						// url left open
						text_bytes.push_back(mds_pkg::CH_RBRK);
						text_bytes.push_back(mds_pkg::CH_LPAR);
						add_word($urandom_range(1, 3));
					end
					endcase
				end
				11: text_bytes.push_back(8'($urandom_range(0, 255)));
				12: text_bytes.push_back(($urandom_range(0, 1) == 1) ?
					mds_pkg::CH_STAR : mds_pkg::CH_DASH);
				default: begin
					case ($urandom_range(0, 2))
					0: text_bytes.push_back(mds_pkg::CH_BANG);
					1: text_bytes.push_back(mds_pkg::CH_QUERY);
					default: text_bytes.push_back(mds_pkg::CH_DOT);
					endcase
				end
				endcase
			end
			foreach (text_bytes[j])
				send_item(text_bytes[j], j == text_bytes.size() - 1, 1'b0, "", 0);
			rand_beats += text_bytes.size();
		end
		in_valid <= 1'b0;

		// Drain: wait for every predicted result, then a little longer for strays.
		while (plain_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
